// ===== design/drud_pkg.sv =====
package drud_pkg;

    localparam int unsigned CoordW  = 16;
    localparam int unsigned ScreenW = 15;
    localparam int unsigned AreaW   = 31;
    localparam int unsigned ProdW   = 30;
    localparam int unsigned FramesW = 8;
    localparam int unsigned SecW    = 32;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;

    localparam logic [ScreenW-1:0] ScreenWidthRst  = 15'd1920;
    localparam logic [ScreenW-1:0] ScreenHeightRst = 15'd1080;
    localparam logic [AreaW-1:0]   AreaThreshRst   = 31'd1036800;
    localparam logic [FramesW-1:0] MinFramesRst    = 8'd3;
    localparam logic [SecW-1:0]    FullIntervalRst = 32'd10;

    localparam logic [AreaW-1:0]   AreaMax   = {AreaW{1'b1}};
    localparam logic [FramesW-1:0] FramesMax = {FramesW{1'b1}};

    typedef enum logic [2:0] {
        REASON_DIRTY     = 3'd0,
        REASON_NO_DAMAGE = 3'd1,
        REASON_WARM_UP   = 3'd2,
        REASON_TIMEOUT   = 3'd3,
        REASON_INVALID   = 3'd4,
        REASON_AREA_OVER = 3'd5
    } t_reason;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_AREA_THRESH   = 3'd2,
        CFG_MIN_FRAMES    = 3'd3,
        CFG_FULL_INTERVAL = 3'd4
    } t_cfg_idx;

endpackage

// ===== design/dirty_rect_update_decider.sv =====
// Per-frame full/dirty update decision. A frame's damage list streams in one
// rectangle per input beat (last_rect marks the final one); a frame with no
// damage list is one beat with cmd set, which also drops any rectangles already
// received for the frame. Each rectangle is bounds and evenness checked and its
// area is added to a saturating per-frame total. On the frame-ending beat one
// output beat gives send_full and a reason code; all other beats give nothing.
// Throughput is one input beat per clock unless a result is held in the output
// register by an output stall: the only loop is the area accumulate and
// frame-state update in stage 2. A beat passes through the input register,
// the check and multiply stage into the stage 2 register, and the accumulate
// and decide stage into the output register. Input stall is raised only while
// a result waits in the output register and the output is stalled.
// Configuration must be written while no frame is in flight.
module dirty_rect_update_decider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [drud_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [drud_pkg::CfgDataW-1:0] i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic signed [drud_pkg::CoordW-1:0] i_rect_x,
    input  logic signed [drud_pkg::CoordW-1:0] i_rect_y,
    input  logic signed [drud_pkg::CoordW-1:0] i_rect_w,
    input  logic signed [drud_pkg::CoordW-1:0] i_rect_h,
    input  logic                          i_last_rect,
    input  logic [drud_pkg::SecW-1:0]     i_now_sec,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_out_send_full,
    output logic [2:0]                    o_out_reason
);
    import drud_pkg::*;

    // configuration registers
    logic [ScreenW-1:0] r_scr_w;
    logic [ScreenW-1:0] r_scr_h;
    logic [AreaW-1:0]   r_area_thresh;
    logic [FramesW-1:0] r_min_frames;
    logic [SecW-1:0]    r_full_interval;

    // stage 1: captured input beat
    logic                     r_s1_valid;
    logic                     r_s1_cmd;
    logic signed [CoordW-1:0] r_s1_x;
    logic signed [CoordW-1:0] r_s1_y;
    logic signed [CoordW-1:0] r_s1_w;
    logic signed [CoordW-1:0] r_s1_h;
    logic                     r_s1_last;
    logic [SecW-1:0]          r_s1_now;

    // stage 2: checked rectangle and its area
    logic             r_s2_valid;
    logic             r_s2_cmd;
    logic             r_s2_ok;
    logic [ProdW-1:0] r_s2_area;
    logic             r_s2_last;
    logic [SecW-1:0]  r_s2_now;

    // frame state
    logic [FramesW-1:0] r_frames_seen;
    logic [SecW-1:0]    r_last_full_sec;
    logic               r_invalid_seen;
    logic [AreaW-1:0]   r_area_total;

    // output register
    logic    r_out_valid;
    logic    r_out_send_full;
    t_reason r_out_reason;

    logic               w_adv;
    logic               w_in_accept;
    logic               n_s2_ok;
    logic [ProdW-1:0]   n_s2_area;
    logic               w_frame_end;
    logic [AreaW-1:0]   n_area_sat;
    t_reason            n_reason;

    // whole pipeline advances unless a result is held by the output side
    assign w_adv       = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !w_adv;
    assign w_in_accept = i_in_valid && w_adv;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w         <= ScreenWidthRst;
            r_scr_h         <= ScreenHeightRst;
            r_area_thresh   <= AreaThreshRst;
            r_min_frames    <= MinFramesRst;
            r_full_interval <= FullIntervalRst;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_scr_w         <= i_cfg_data[ScreenW-1:0];
                CFG_SCREEN_HEIGHT: r_scr_h         <= i_cfg_data[ScreenW-1:0];
                CFG_AREA_THRESH:   r_area_thresh   <= i_cfg_data[AreaW-1:0];
                CFG_MIN_FRAMES:    r_min_frames    <= i_cfg_data[FramesW-1:0];
                CFG_FULL_INTERVAL: r_full_interval <= i_cfg_data[SecW-1:0];
                default: ;
            endcase
        end
    end

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_cmd  <= i_cmd;
            r_s1_x    <= i_rect_x;
            r_s1_y    <= i_rect_y;
            r_s1_w    <= i_rect_w;
            r_s1_h    <= i_rect_h;
            r_s1_last <= i_last_rect;
            r_s1_now  <= i_now_sec;
        end
    end

    // rectangle check and area product
    always_comb begin
        logic signed [CoordW:0] sw_ext;
        logic signed [CoordW:0] sh_ext;
        logic signed [CoordW:0] x_ext;
        logic signed [CoordW:0] y_ext;
        logic signed [CoordW:0] w_ext;
        logic signed [CoordW:0] h_ext;
        logic signed [CoordW:0] room_w;
        logic signed [CoordW:0] room_h;
        sw_ext = $signed({2'b00, r_scr_w});
        sh_ext = $signed({2'b00, r_scr_h});
        x_ext  = $signed({r_s1_x[CoordW-1], r_s1_x});
        y_ext  = $signed({r_s1_y[CoordW-1], r_s1_y});
        w_ext  = $signed({r_s1_w[CoordW-1], r_s1_w});
        h_ext  = $signed({r_s1_h[CoordW-1], r_s1_h});
        room_w = sw_ext - x_ext;
        room_h = sh_ext - y_ext;
        n_s2_ok = !r_s1_x[CoordW-1] && !r_s1_y[CoordW-1]
               && (x_ext <= sw_ext) && (y_ext <= sh_ext)
               && !r_s1_x[0] && !r_s1_w[0]
               && !r_s1_w[CoordW-1] && !r_s1_h[CoordW-1]
               && (w_ext <= room_w) && (h_ext <= room_h);
        // valid sizes are non-negative and fit in 15 bits
        n_s2_area = n_s2_ok ? r_s1_w[ScreenW-1:0] * r_s1_h[ScreenW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_s2_cmd  <= r_s1_cmd;
            r_s2_ok   <= n_s2_ok;
            r_s2_area <= n_s2_area;
            r_s2_last <= r_s1_last;
            r_s2_now  <= r_s1_now;
        end
    end

    // accumulate and decide
    always_comb begin
        logic [AreaW:0] sum;
        logic [SecW-1:0] elapsed;
        logic           inv;
        sum        = {1'b0, r_area_total} + {2'b00, r_s2_area};
        n_area_sat = sum[AreaW] ? AreaMax : sum[AreaW-1:0];
        elapsed    = r_s2_now - r_last_full_sec;
        inv        = r_invalid_seen || !r_s2_ok;
        w_frame_end = r_s2_cmd || r_s2_last;
        if (r_s2_cmd) begin
            n_reason = REASON_NO_DAMAGE;
        end else if (r_frames_seen < r_min_frames) begin
            n_reason = REASON_WARM_UP;
        end else if (elapsed >= r_full_interval) begin
            n_reason = REASON_TIMEOUT;
        end else if (inv) begin
            n_reason = REASON_INVALID;
        end else if (n_area_sat > r_area_thresh) begin
            n_reason = REASON_AREA_OVER;
        end else begin
            n_reason = REASON_DIRTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_seen   <= '0;
            r_last_full_sec <= '0;
            r_invalid_seen  <= 1'b0;
            r_area_total    <= '0;
        end else if (w_adv && r_s2_valid) begin
            if (w_frame_end) begin
                r_area_total   <= '0;
                r_invalid_seen <= 1'b0;
                if (r_frames_seen != FramesMax) begin
                    r_frames_seen <= r_frames_seen + 1'b1;
                end
                if (n_reason != REASON_DIRTY) begin
                    r_last_full_sec <= r_s2_now;
                end
            end else begin
                r_area_total <= n_area_sat;
                if (!r_s2_ok) begin
                    r_invalid_seen <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s2_valid && w_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_valid && w_frame_end) begin
            r_out_send_full <= (n_reason != REASON_DIRTY);
            r_out_reason    <= n_reason;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_send_full = r_out_send_full;
    assign o_out_reason    = r_out_reason;

    // decision bit agrees with the reason code
    a_full_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_send_full == (r_out_reason != REASON_DIRTY)))
        else $error("send_full disagrees with reason");

    // input is held off only by a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled with empty output register");

    // an accepted beat enters stage 1
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_s1_valid)
        else $error("accepted beat lost");

    // frame end clears the per-frame state
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s2_valid && w_frame_end) |=> (r_area_total == '0 && !r_invalid_seen))
        else $error("frame state not cleared at frame end");

    // frame counter never goes down
    a_frames_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_frames_seen >= $past(r_frames_seen)))
        else $error("frame counter decreased");

endmodule

// ===== tb/tb_dirty_rect_update_decider.sv =====
module tb_dirty_rect_update_decider;
    import drud_pkg::*;

    // one input beat: a damage rectangle or an empty-list frame
    typedef struct {
        bit                       cmd;
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] w;
        logic signed [CoordW-1:0] h;
        bit                       last;
        bit [SecW-1:0]            now;
    } t_rect_beat;

    // one output beat: the frame decision
    typedef struct {
        bit      send_full;
        t_reason reason;
    } t_decision;

    // mirrors the register file and the per-frame state, and queues the
    // decision each frame-ending beat is due to produce
    class decision_tracker;
        bit [ScreenW-1:0] scr_w;
        bit [ScreenW-1:0] scr_h;
        bit [AreaW-1:0]   area_limit;
        bit [FramesW-1:0] warm_frames;
        bit [SecW-1:0]    full_every;
        bit [FramesW-1:0] frames_done;
        bit [SecW-1:0]    last_full;
        bit               bad_rect;
        longint           area_sum;
        t_decision        decisions_due[$];
        int               errors;

        function new();
            scr_w       = ScreenWidthRst;
            scr_h       = ScreenHeightRst;
            area_limit  = AreaThreshRst;
            warm_frames = MinFramesRst;
            full_every  = FullIntervalRst;
            frames_done = '0;
            last_full   = '0;
            bad_rect    = 1'b0;
            area_sum    = 0;
            errors      = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, bit [CfgDataW-1:0] val);
            case (idx)
                CFG_SCREEN_WIDTH:  scr_w = val[ScreenW-1:0];
                CFG_SCREEN_HEIGHT: scr_h = val[ScreenW-1:0];
                CFG_AREA_THRESH:   area_limit = val[AreaW-1:0];
                CFG_MIN_FRAMES:    warm_frames = val[FramesW-1:0];
                CFG_FULL_INTERVAL: full_every = val[SecW-1:0];
                default: ;
            endcase
        endfunction

        function void note_beat(t_rect_beat b);
            int            sw, sh, x, y, w, h;
            longint        sum;
            bit [SecW-1:0] elapsed;
            t_reason       why;
            sw = int'(scr_w);
            sh = int'(scr_h);
            if (!b.cmd) begin
                x = int'(b.x);
                y = int'(b.y);
                w = int'(b.w);
                h = int'(b.h);
                if (x < 0 || x > sw || y < 0 || y > sh || x[0] || w < 0 || w[0] || h < 0 ||
                    w > sw - x || h > sh - y) begin
                    bad_rect = 1'b1;
                end else begin
                    // saturating area sum, invalid rectangles add nothing
                    sum = area_sum + longint'(w) * longint'(h);
                    area_sum = (sum > longint'(AreaMax)) ? longint'(AreaMax) : sum;
                end
                if (!b.last) return;
            end
            elapsed = b.now - last_full;
            if (b.cmd)
                why = REASON_NO_DAMAGE;
            else if (frames_done < warm_frames)
                why = REASON_WARM_UP;
            else if (elapsed >= full_every)
                why = REASON_TIMEOUT;
            else if (bad_rect)
                why = REASON_INVALID;
            else if (area_sum > longint'(area_limit))
                why = REASON_AREA_OVER;
            else
                why = REASON_DIRTY;
            if (why != REASON_DIRTY) last_full = b.now;
            if (frames_done != FramesMax) frames_done++;
            area_sum = 0;
            bad_rect = 1'b0;
            decisions_due.push_back('{send_full: (why != REASON_DIRTY), reason: why});
        endfunction

        function void check_decision(logic full, logic [2:0] why);
            t_decision want;
            if (decisions_due.size() == 0) begin
                $error("decision with none outstanding: send_full %0d reason %0d", full, why);
                errors++;
                return;
            end
            want = decisions_due.pop_front();
            if (full !== want.send_full) begin
                $error("send_full: expected %0d, got %0d", want.send_full, full);
                errors++;
            end
            if (why !== want.reason) begin
                $error("reason: expected %0d, got %0d", want.reason, why);
                errors++;
            end
        endfunction

        function int pending();
            return decisions_due.size();
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CfgIdxW-1:0]         i_cfg_index;
    logic [CfgDataW-1:0]        i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_cmd;
    logic signed [CoordW-1:0]   i_rect_x;
    logic signed [CoordW-1:0]   i_rect_y;
    logic signed [CoordW-1:0]   i_rect_w;
    logic signed [CoordW-1:0]   i_rect_h;
    logic                       i_last_rect;
    logic [SecW-1:0]            i_now_sec;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic                       o_out_send_full;
    logic [2:0]                 o_out_reason;

    dirty_rect_update_decider DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_rect_x        (i_rect_x),
        .i_rect_y        (i_rect_y),
        .i_rect_w        (i_rect_w),
        .i_rect_h        (i_rect_h),
        .i_last_rect     (i_last_rect),
        .i_now_sec       (i_now_sec),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_send_full (o_out_send_full),
        .o_out_reason    (o_out_reason)
    );

    decision_tracker tracker = new();

    // stimulus state shared with the receiver process
    bit [SecW-1:0] cur_sec      = '0;
    int            beats_sent   = 0;
    bit            sender_idles = 1'b0;
    int            burst_left   = 0;
    int            stall_pct    = 0;
    int            hold_left    = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs or a decision never shows up
    initial begin
        #800000;
        $display("tb_dirty_rect_update_decider NOT OK");
        $finish;
    end

    // receiver: a long hold-off when asked, else random stall per cycle
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (stall_pct == 0) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99, 0) < stall_pct);
            end
        end
    end

    // output monitor, sees pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            tracker.check_decision(o_out_send_full, o_out_reason);
    end

    // offer one beat and hold it until accepted; bursts with random gaps
    task automatic send_beat(t_rect_beat b);
        if (sender_idles && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
            burst_left = $urandom_range(16, 1);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= b.cmd;
        i_rect_x    <= b.x;
        i_rect_y    <= b.y;
        i_rect_w    <= b.w;
        i_rect_h    <= b.h;
        i_last_rect <= b.last;
        i_now_sec   <= b.now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_beat(b);
        beats_sent++;
        if (burst_left > 0) burst_left--;
    endtask

    // empty damage list, rect fields are don't-care so randomize them
    task automatic send_empty();
        t_rect_beat r;
        r.cmd  = 1'b1;
        r.x    = CoordW'($urandom());
        r.y    = CoordW'($urandom());
        r.w    = CoordW'($urandom());
        r.h    = CoordW'($urandom());
        r.last = 1'($urandom_range(1, 0));
        r.now  = cur_sec;
        send_beat(r);
    endtask

    function automatic t_rect_beat mk_rect(int x, int y, int w, int h, bit last,
                                           bit [SecW-1:0] now);
        t_rect_beat r;
        r.cmd  = 1'b0;
        r.x    = CoordW'(x);
        r.y    = CoordW'(y);
        r.w    = CoordW'(w);
        r.h    = CoordW'(h);
        r.last = last;
        r.now  = now;
        return r;
    endfunction

    // in-bounds rectangle: size_mode 0 small, 1 mixed, 2 near full screen
    function automatic t_rect_beat good_rect(int size_mode);
        t_rect_beat r;
        int sw, sh, room, pick;
        sw = int'(tracker.scr_w);
        sh = int'(tracker.scr_h);
        pick = (size_mode == 2) ? 0 : (size_mode == 0) ? 99 : $urandom_range(99, 0);
        r.cmd  = 1'b0;
        r.last = 1'b0;
        r.now  = $urandom();
        if (pick < 15) begin
            r.x = CoordW'(2 * $urandom_range((sw < 16 ? sw : 16) / 2, 0));
            r.y = CoordW'($urandom_range(sh < 16 ? sh : 16, 0));
            r.w = CoordW'(((sw - r.x) / 2) * 2);
            r.h = CoordW'(sh - r.y);
        end else begin
            r.x = CoordW'(2 * $urandom_range(sw / 2, 0));
            r.y = CoordW'($urandom_range(sh, 0));
            room = (sw - r.x) / 2;
            if (pick >= 40 && room > 32) room = 32;
            r.w = CoordW'(2 * $urandom_range(room, 0));
            room = sh - r.y;
            if (pick >= 40 && room > 64) room = 64;
            r.h = CoordW'($urandom_range(room, 0));
        end
        return r;
    endfunction

    // one rule broken on purpose, or plain noise
    function automatic t_rect_beat broken_rect();
        t_rect_beat r;
        int sw, sh;
        sw = int'(tracker.scr_w);
        sh = int'(tracker.scr_h);
        r = good_rect(0);
        case ($urandom_range(10, 0))
            0: r.x[0] = 1'b1;
            1: r.x = CoordW'(-int'($urandom_range(32768, 1)));
            2: r.x = CoordW'(sw + int'($urandom_range(32767 - sw, 1)));
            3: r.y = CoordW'(-int'($urandom_range(32768, 1)));
            4: r.y = CoordW'(sh + int'($urandom_range(32767 - sh, 1)));
            5: r.w[0] = 1'b1;
            6: r.w = CoordW'(-int'($urandom_range(32768, 1)));
            7: r.w = CoordW'(sw - r.x + 2);
            8: r.h = CoordW'(-int'($urandom_range(32768, 1)));
            9: r.h = CoordW'(sh - r.y + 1);
            default: begin
                r.x = CoordW'($urandom());
                r.y = CoordW'($urandom());
                r.w = CoordW'($urandom());
                r.h = CoordW'($urandom());
            end
        endcase
        return r;
    endfunction

    // frame time: mostly creeping, sometimes right at the timeout edge or a jump
    task automatic advance_clock();
        int p;
        p = $urandom_range(99, 0);
        if (p < 4)
            cur_sec = $urandom();
        else if (p < 8)
            cur_sec = tracker.last_full + tracker.full_every;
        else if (p < 12)
            cur_sec = tracker.last_full + tracker.full_every - 1;
        else
            cur_sec += $urandom_range(1, 0);
    endtask

    // empty frame, aborted list, or a list of rectangles closed by last_rect
    task automatic random_frame(int most_rects, int size_mode);
        t_rect_beat r;
        int kind, n;
        kind = $urandom_range(99, 0);
        advance_clock();
        if (kind < 10) begin
            send_empty();
        end else begin
            n = $urandom_range(most_rects, 1);
            for (int i = 0; i < n; i++) begin
                r = ($urandom_range(99, 0) < 12) ? broken_rect() : good_rect(size_mode);
                r.last = (kind >= 18) && (i == n - 1);
                if (r.last) r.now = cur_sec;
                send_beat(r);
            end
            // aborted list, the empty beat drops what came before
            if (kind < 18) send_empty();
        end
    endtask

    // block drained: nothing owed, plus room for rect beats still in the pipe
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // write enable stays up across back-to-back writes
    task automatic write_reg(t_cfg_idx idx, bit [CfgDataW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic load_regs(bit [CfgDataW-1:0] sw, bit [CfgDataW-1:0] sh,
                             bit [CfgDataW-1:0] thr, bit [CfgDataW-1:0] warm,
                             bit [CfgDataW-1:0] every);
        write_reg(CFG_SCREEN_WIDTH, sw);
        write_reg(CFG_SCREEN_HEIGHT, sh);
        write_reg(CFG_AREA_THRESH, thr);
        write_reg(CFG_MIN_FRAMES, warm);
        write_reg(CFG_FULL_INTERVAL, every);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(bit [CfgDataW-1:0] sw, bit [CfgDataW-1:0] sh,
                             bit [CfgDataW-1:0] thr, bit [CfgDataW-1:0] warm,
                             bit [CfgDataW-1:0] every, int beats, int most_rects,
                             int size_mode);
        int goal;
        settle();
        load_regs(sw, sh, thr, warm, every);
        sender_idles = 1'($urandom_range(1, 0));
        burst_left   = 0;
        stall_pct    = $urandom_range(1, 0) ? int'($urandom_range(60, 10)) : 0;
        goal = beats_sent + beats;
        while (beats_sent < goal) random_frame(most_rects, size_mode);
    endtask

    initial begin
        int goal;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_SCREEN_WIDTH;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_cmd       <= 1'b0;
        i_rect_x    <= '0;
        i_rect_y    <= '0;
        i_rect_w    <= '0;
        i_rect_h    <= '0;
        i_last_rect <= 1'b0;
        i_now_sec   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats at reset register values (1920x1080, thr 1036800,
        // three warm-up frames, 10 s interval)
        sender_idles = 1'b1;
        stall_pct    = 30;
        cur_sec = 0;
        send_empty();                                        // no damage
        send_beat(mk_rect(0, 0, 1920, 1080, 1'b1, 1));       // warm-up, full screen
        send_beat(mk_rect(1920, 1080, 0, 0, 1'b1, 2));       // warm-up, corner, zero size
        send_beat(mk_rect(0, 0, 1920, 540, 1'b1, 3));        // area equals threshold: dirty
        send_beat(mk_rect(0, 0, 1920, 540, 1'b0, $urandom()));
        send_beat(mk_rect(0, 540, 2, 1, 1'b1, 4));           // two over threshold
        send_beat(mk_rect(-32768, -32768, -32768, -32768, 1'b0, $urandom()));
        send_beat(mk_rect(32767, 32767, 32767, 32767, 1'b0, $urandom()));
        send_beat(mk_rect(1, 0, 2, 2, 1'b0, $urandom()));    // odd x
        send_beat(mk_rect(0, 0, 3, 2, 1'b1, 5));             // odd w
        send_beat(mk_rect(0, 1081, 0, 0, 1'b1, 6));          // y past bottom
        send_beat(mk_rect(1922, 0, 0, 0, 1'b1, 7));          // x past right
        send_beat(mk_rect(2, 0, 1920, 2, 1'b1, 8));          // w too wide
        send_beat(mk_rect(0, 2, 2, 1079, 1'b1, 9));          // h too tall
        send_beat(mk_rect(0, 0, 0, -1, 1'b1, 10));           // negative h
        send_beat(mk_rect(0, 0, 2, 2, 1'b1, 20));            // exactly interval: timeout
        send_beat(mk_rect(0, 0, 2, 2, 1'b1, 29));            // one short of it: dirty
        send_beat(mk_rect(0, 0, 4, 4, 1'b0, $urandom()));    // list cut by empty beat
        cur_sec = 29;
        send_empty();
        cur_sec = 32'hFFFF_FFFF;
        send_empty();                                        // last full at top of range
        send_beat(mk_rect(0, 0, 2, 2, 1'b1, 3));             // elapsed wraps to 4: dirty

        // random phases, every register written each time
        run_phase(1920, 1080, 1036800, 3, 10, 70, 5, 1);
        run_phase(16384, 16384, 32'h7FFF_FFFF, 255, 32'hFFFF_FFFF, 50, 4, 2);

        // output held off on its own count while empties pour in, so the
        // block backs up and stalls its input
        settle();
        load_regs(640, 480, 100000, 0, 1000);
        sender_idles = 1'b0;
        stall_pct    = 0;
        hold_left    = 150;
        repeat (100) begin
            advance_clock();
            send_empty();
        end
        // sender waits for every decision before going on
        settle();
        sender_idles = 1'b1;
        stall_pct    = 40;
        goal = beats_sent + 40;
        while (beats_sent < goal) random_frame(4, 1);

        run_phase(0, 0, 0, 0, 32'hFFFF_FFFF, 40, 3, 0);
        run_phase(1920, 1080, 1036800, 0, 0, 30, 3, 1);
        repeat (2)
            run_phase($urandom_range(16384, 0), $urandom_range(16384, 0),
                      $urandom_range(300000, 0), $urandom_range(255, 0),
                      $urandom_range(40, 1), 50, 5, 1);

        // frame count saturated now: warm-up never wins even at 255;
        // big lists saturate the area sum, which never exceeds max threshold
        run_phase(16384, 16384, 32'h7FFF_FFFF, 255, 32'hFFFF_FFFF, 60, 12, 2);
        cur_sec = tracker.last_full - 1;                     // elapsed all ones: timeout
        send_beat(mk_rect(0, 0, 2, 2, 1'b1, cur_sec));
        // one below the saturated sum does fire
        run_phase(16384, 16384, 32'h7FFF_FFFE, 255, 32'hFFFF_FFFF, 40, 12, 2);
        run_phase(1920, 1080, 1036800, 1, 10, 50, 5, 1);

        settle();
        repeat (12) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("tb_dirty_rect_update_decider OK");
        else
            $display("tb_dirty_rect_update_decider NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
design/drud_pkg.sv
design/dirty_rect_update_decider.sv
tb/tb_dirty_rect_update_decider.sv
